// ----- sv/dsre_pkg.sv -----
// Package for the dual stack rotate engine: sizes, command codes, micro-ops,
// the controller/datapath structs and the address helpers.
// No dependencies.
package dsre_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = CW + 1;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 4;
  localparam int CNT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_SWAP_A   = 4'd0,
    CMD_SWAP_B   = 4'd1,
    CMD_ROT_A    = 4'd2,
    CMD_ROT_B    = 4'd3,
    CMD_REVROT_A = 4'd4,
    CMD_REVROT_B = 4'd5,
    CMD_PUSH_A   = 4'd6,
    CMD_PUSH_B   = 4'd7,
    CMD_APPEND_A = 4'd8,
    CMD_APPEND_B = 4'd9,
    CMD_CLEAR    = 4'd10
  } cmd_t;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_SWAP_RD,
    UOP_SWAP_WR1,
    UOP_SWAP_WR2,
    UOP_ROT_WR,
    UOP_RD_TOP,
    UOP_LD_TOP,
    UOP_REV_RD,
    UOP_REV_WR,
    UOP_PUSH,
    UOP_APPEND,
    UOP_CLEAR
  } uop_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic empty;
    logic lt2;
    logic full;
  } stk_status_t;

  typedef struct packed {
    stk_status_t a;
    stk_status_t b;
  } dp_status_t;

  typedef struct packed {
    logic capture;
    uop_t uop;
    logic sel_b;
  } dp_cmd_t;

  typedef struct packed {
    uop_t uop;
    logic sel_b;
    logic last;
  } plan_t;

  // Index k places below head h, wrapped into 0..DEPTH-1 (h < DEPTH, k <= DEPTH).
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h,
                                             input logic [CW-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(k);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] h);
    return (h == '0) ? AW'(DEPTH - 1) : h - AW'(1);
  endfunction

  function automatic logic refuse(input logic [CMD_W-1:0] cmd, input dp_status_t st);
    logic r;
    case (cmd)
      CMD_SWAP_A:   r = st.a.lt2;
      CMD_SWAP_B:   r = st.b.lt2;
      CMD_ROT_A:    r = st.a.empty;
      CMD_ROT_B:    r = st.b.empty;
      CMD_REVROT_A: r = st.a.empty;
      CMD_REVROT_B: r = st.b.empty;
      CMD_PUSH_A:   r = st.b.empty | st.a.full;
      CMD_PUSH_B:   r = st.a.empty | st.b.full;
      CMD_APPEND_A: r = st.a.full;
      CMD_APPEND_B: r = st.b.full;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  // Micro-op sequence of each command; sel_b picks the stack the step works on.
  function automatic plan_t plan(input logic [CMD_W-1:0] cmd, input logic [1:0] step);
    plan_t p;
    logic  b;
    p = '{uop: UOP_NONE, sel_b: 1'b0, last: 1'b1};
    b = cmd[0];
    case (cmd)
      CMD_SWAP_A, CMD_SWAP_B: begin
        case (step)
          2'd0:    p = '{uop: UOP_SWAP_RD,  sel_b: b, last: 1'b0};
          2'd1:    p = '{uop: UOP_SWAP_WR1, sel_b: b, last: 1'b0};
          default: p = '{uop: UOP_SWAP_WR2, sel_b: b, last: 1'b1};
        endcase
      end
      CMD_ROT_A, CMD_ROT_B: begin
        case (step)
          2'd0:    p = '{uop: UOP_ROT_WR, sel_b: b, last: 1'b0};
          2'd1:    p = '{uop: UOP_RD_TOP, sel_b: b, last: 1'b0};
          default: p = '{uop: UOP_LD_TOP, sel_b: b, last: 1'b1};
        endcase
      end
      CMD_REVROT_A, CMD_REVROT_B: begin
        case (step)
          2'd0:    p = '{uop: UOP_REV_RD, sel_b: b, last: 1'b0};
          default: p = '{uop: UOP_REV_WR, sel_b: b, last: 1'b1};
        endcase
      end
      CMD_PUSH_A, CMD_PUSH_B: begin
        // destination first, then refetch the source's new top
        case (step)
          2'd0:    p = '{uop: UOP_PUSH,   sel_b: b,  last: 1'b0};
          2'd1:    p = '{uop: UOP_RD_TOP, sel_b: ~b, last: 1'b0};
          default: p = '{uop: UOP_LD_TOP, sel_b: ~b, last: 1'b1};
        endcase
      end
      CMD_APPEND_A, CMD_APPEND_B: p = '{uop: UOP_APPEND, sel_b: b, last: 1'b1};
      CMD_CLEAR:                  p = '{uop: UOP_CLEAR,  sel_b: 1'b0, last: 1'b1};
      default:                    p = '{uop: UOP_NONE,   sel_b: 1'b0, last: 1'b1};
    endcase
    return p;
  endfunction

endpackage

// ----- sv/dsre_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dsre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/dsre_datapath.sv -----
// Datapath: the two stack stores, head and fill registers and cached tops.
// Depends on dsre_pkg and dsre_ram; driven by dsre_ctrl micro-ops.
module dsre_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsre_pkg::dp_cmd_t             cmd,
  input  logic signed [31:0]            in_value,
  output dsre_pkg::dp_status_t          status,
  output logic signed [31:0]            out_top_a,
  output logic signed [31:0]            out_top_b,
  output logic [5:0]                    out_count_a,
  output logic [5:0]                    out_count_b
);
  import dsre_pkg::*;

  logic [AW-1:0]     head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic [CW-1:0]     fill_a_r, fill_a_nxt, fill_b_r, fill_b_nxt;
  logic [WORD_W-1:0] top_a_r, top_a_nxt, top_b_r, top_b_nxt;
  logic [WORD_W-1:0] value_r;

  // selected stack (s_) and the other one (o_)
  logic [AW-1:0]     s_head, o_head, s_head_nxt, o_head_nxt;
  logic [CW-1:0]     s_fill, o_fill, s_fill_nxt, o_fill_nxt;
  logic [WORD_W-1:0] s_top, o_top, s_top_nxt, s_rdata;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rd_a, rd_b;

  assign s_head  = cmd.sel_b ? head_b_r : head_a_r;
  assign o_head  = cmd.sel_b ? head_a_r : head_b_r;
  assign s_fill  = cmd.sel_b ? fill_b_r : fill_a_r;
  assign o_fill  = cmd.sel_b ? fill_a_r : fill_b_r;
  assign s_top   = cmd.sel_b ? top_b_r  : top_a_r;
  assign o_top   = cmd.sel_b ? top_a_r  : top_b_r;
  assign s_rdata = cmd.sel_b ? rd_b     : rd_a;

  always_comb begin
    s_head_nxt = s_head;
    o_head_nxt = o_head;
    s_fill_nxt = s_fill;
    o_fill_nxt = o_fill;
    s_top_nxt  = s_top;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = s_head;
    raddr      = s_head;
    wdata      = s_top;
    case (cmd.uop)
      UOP_SWAP_RD: begin
        re    = 1'b1;
        raddr = wrap_add(s_head, CW'(1));
      end
      UOP_SWAP_WR1: begin
        we        = 1'b1;
        waddr     = wrap_add(s_head, CW'(1));
        s_top_nxt = s_rdata;
      end
      UOP_SWAP_WR2: begin
        we = 1'b1;
      end
      UOP_ROT_WR: begin
        we         = 1'b1;
        waddr      = wrap_add(s_head, s_fill);
        s_head_nxt = wrap_add(s_head, CW'(1));
      end
      UOP_RD_TOP: begin
        re = 1'b1;
      end
      UOP_LD_TOP: begin
        s_top_nxt = s_rdata;
      end
      UOP_REV_RD: begin
        re    = 1'b1;
        raddr = wrap_add(s_head, s_fill - CW'(1));
      end
      UOP_REV_WR: begin
        we         = 1'b1;
        waddr      = step_up(s_head);
        wdata      = s_rdata;
        s_top_nxt  = s_rdata;
        s_head_nxt = step_up(s_head);
      end
      UOP_PUSH: begin
        we         = 1'b1;
        waddr      = step_up(s_head);
        wdata      = o_top;
        s_top_nxt  = o_top;
        s_head_nxt = step_up(s_head);
        s_fill_nxt = s_fill + CW'(1);
        o_head_nxt = wrap_add(o_head, CW'(1));
        o_fill_nxt = o_fill - CW'(1);
      end
      UOP_APPEND: begin
        we         = 1'b1;
        waddr      = wrap_add(s_head, s_fill);
        wdata      = value_r;
        s_fill_nxt = s_fill + CW'(1);
        if (s_fill == '0) begin
          s_top_nxt = value_r;
        end
      end
      UOP_CLEAR: begin
        s_head_nxt = '0;
        o_head_nxt = '0;
        s_fill_nxt = '0;
        o_fill_nxt = '0;
      end
      default: begin
      end
    endcase

    if (cmd.sel_b) begin
      head_b_nxt = s_head_nxt;
      head_a_nxt = o_head_nxt;
      fill_b_nxt = s_fill_nxt;
      fill_a_nxt = o_fill_nxt;
      top_b_nxt  = s_top_nxt;
      top_a_nxt  = top_a_r;
    end else begin
      head_a_nxt = s_head_nxt;
      head_b_nxt = o_head_nxt;
      fill_a_nxt = s_fill_nxt;
      fill_b_nxt = o_fill_nxt;
      top_a_nxt  = s_top_nxt;
      top_b_nxt  = top_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_a_r <= '0;
      head_b_r <= '0;
      fill_a_r <= '0;
      fill_b_r <= '0;
    end else begin
      head_a_r <= head_a_nxt;
      head_b_r <= head_b_nxt;
      fill_a_r <= fill_a_nxt;
      fill_b_r <= fill_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_a_r <= top_a_nxt;
    top_b_r <= top_b_nxt;
    if (cmd.capture) begin
      value_r <= in_value;
    end
  end

  dsre_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (we & ~cmd.sel_b),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (re & ~cmd.sel_b),
    .rd_addr (raddr),
    .rd_data (rd_a)
  );

  dsre_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (we & cmd.sel_b),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (re & cmd.sel_b),
    .rd_addr (raddr),
    .rd_data (rd_b)
  );

  assign status.a.empty = (fill_a_r == '0);
  assign status.a.lt2   = (fill_a_r < CW'(2));
  assign status.a.full  = (fill_a_r >= CW'(DEPTH));
  assign status.b.empty = (fill_b_r == '0);
  assign status.b.lt2   = (fill_b_r < CW'(2));
  assign status.b.full  = (fill_b_r >= CW'(DEPTH));

  // cached top is only meaningful while the stack holds something
  assign out_top_a   = (fill_a_r != '0) ? top_a_r : '0;
  assign out_top_b   = (fill_b_r != '0) ? top_b_r : '0;
  assign out_count_a = CNT_W'(fill_a_r);
  assign out_count_b = CNT_W'(fill_b_r);

endmodule

// ----- sv/dsre_ctrl.sv -----
// Controller: accepts an item, checks it against the stack status and
// sequences the datapath micro-ops. Depends on dsre_pkg.
module dsre_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_command,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_refused,
  input  dsre_pkg::dp_status_t status,
  output dsre_pkg::dp_cmd_t    cmd
);
  import dsre_pkg::*;

  state_t           state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [CMD_W-1:0] op_r, op_nxt;
  logic             refused_r, refused_nxt;
  logic             accept;
  plan_t            p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      op_r      <= '0;
      refused_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      op_r      <= op_nxt;
      refused_r <= refused_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    op_nxt      = op_r;
    refused_nxt = refused_r;
    accept      = 1'b0;
    p           = plan(op_r, step_r);
    cmd         = '{capture: 1'b0, uop: UOP_NONE, sel_b: 1'b0};
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        accept      = in_valid;
        cmd.capture = accept;
        if (accept) begin
          op_nxt      = in_command;
          refused_nxt = refuse(in_command, status);
          step_nxt    = '0;
          // refused and unknown codes change nothing: straight to the result
          if (refuse(in_command, status) || (in_command > CMD_CLEAR)) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.uop   = p.uop;
        cmd.sel_b = p.sel_b;
        step_nxt  = step_r + 2'd1;
        if (p.last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_refused = refused_r;

endmodule

// ----- sv/dual_stack_rotate_engine.sv -----
// Top level of the dual stack rotate engine: two bounded stacks of 32-bit
// words driven by one command per item. Depends on dsre_pkg, dsre_ctrl,
// dsre_datapath and dsre_ram.
//
// Usage:
//   Input channel in_valid/in_stall carries in_command and in_value; an item
//   is taken on a rising edge with in_valid high and in_stall low.
//   Result channel out_valid/out_stall carries both tops, both counts and the
//   refused flag, one result per item, in order.
//   One item at a time: after acceptance the controller runs the micro-ops
//   of the command on the stack stores (swap: read, write, write; rotate:
//   write, read top, load top; push: push, read top, load top; reverse
//   rotate: read, write; append: write; clear: reset), then presents the
//   result. Refused commands and unknown codes skip the micro-ops. The
//   micro-ops are split this way by the single write and single read port
//   of each store. The next item is taken only after the result has left.
//   While out_stall is high the result holds and in_stall stays high.
//   Reset (rst_n low, synchronous) empties both stacks and clears the heads;
//   store contents are not cleared and never reach a result unwritten.
module dual_stack_rotate_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_top_a,
  output logic signed [31:0] out_top_b,
  output logic [5:0]         out_count_a,
  output logic [5:0]         out_count_b,
  output logic               out_refused
);
  import dsre_pkg::*;

  dp_status_t status;
  dp_cmd_t    cmd;

  dsre_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_refused (out_refused),
    .status      (status),
    .cmd         (cmd)
  );

  dsre_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_value    (in_value),
    .status      (status),
    .out_top_a   (out_top_a),
    .out_top_b   (out_top_b),
    .out_count_a (out_count_a),
    .out_count_b (out_count_b)
  );

endmodule
